### design/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mbps_pkg;

  // Fixed field widths of the configuration and result channels.
  localparam int SIG_WORD_W      = 64;
  localparam int CARE_W          = 16;
  localparam int LEN_W           = 5;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 64;
  localparam int RESULT_OFFSET_W = 32;

  // Register index taken from paddr[4:3].
  typedef enum logic [1:0] {
    REG_SIG_LOW  = 2'd0,
    REG_SIG_HIGH = 2'd1,
    REG_CARE     = 2'd2,
    REG_LENGTH   = 2'd3
  } cfg_reg_t;

  // One result item.
  typedef struct packed {
    logic                       found;
    logic [RESULT_OFFSET_W-1:0] offset;
  } result_t;

endpackage

### design/mbps_cfg.sv
// Configuration registers of the pattern search with the APB-style access port.
// Also presents the signature realigned to the window order. Depends on mbps_pkg.
`timescale 1ns / 1ps

module mbps_cfg #(
  parameter int MAX_SIGNATURE_LEN = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [mbps_pkg::LEN_W-1:0]         len_eff,
  output logic [MAX_SIGNATURE_LEN*8-1:0]     win_sig,
  output logic [MAX_SIGNATURE_LEN-1:0]       win_care
);
  import mbps_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SIGNATURE_LEN);

  logic [SIG_WORD_W-1:0] signature_low;
  logic [SIG_WORD_W-1:0] signature_high;
  logic [CARE_W-1:0]     care_mask;
  logic [LEN_W-1:0]      signature_length;

  logic                    wr_en;
  cfg_reg_t                reg_sel;
  logic [2*SIG_WORD_W-1:0] sig_all;
  logic [LEN_W-1:0]        src_idx [MAX_SIGNATURE_LEN];

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[4:3]);
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes at the access cycle of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      signature_low    <= '0;
      signature_high   <= '0;
      care_mask        <= '1;
      signature_length <= LEN_W'(1);
    end else if (wr_en) begin
      case (reg_sel)
        REG_SIG_LOW:  signature_low    <= pwdata[SIG_WORD_W-1:0];
        REG_SIG_HIGH: signature_high   <= pwdata[SIG_WORD_W-1:0];
        REG_CARE:     care_mask        <= pwdata[CARE_W-1:0];
        REG_LENGTH:   signature_length <= pwdata[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  // Read data returns the addressed register.
  always_comb begin
    case (reg_sel)
      REG_SIG_LOW:  prdata = signature_low;
      REG_SIG_HIGH: prdata = signature_high;
      REG_CARE:     prdata = CFG_DATA_W'(care_mask);
      REG_LENGTH:   prdata = CFG_DATA_W'(signature_length);
      default:      prdata = '0;
    endcase
  end

  // A length of zero counts as one; lengths above the window clamp to it.
  always_comb begin
    if (signature_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (signature_length > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = signature_length;
    end
  end

  assign sig_all = {signature_high, signature_low};

  // Window slot j holds the byte that must equal signature byte len-1-j.
  // Slots at or beyond the length are wildcards.
  always_comb begin
    for (int j = 0; j < MAX_SIGNATURE_LEN; j++) begin
      src_idx[j] = len_eff - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) < len_eff) begin
        win_care[j]       = care_mask[src_idx[j][3:0]];
        win_sig[j*8 +: 8] = sig_all[src_idx[j][3:0]*8 +: 8];
      end else begin
        win_care[j]       = 1'b0;
        win_sig[j*8 +: 8] = 8'h00;
      end
    end
  end

endmodule

### design/mbps_scan.sv
// Scan state of the pattern search: byte window, position counter, match flag,
// and the single-pass window compare. Depends on mbps_pkg.
`timescale 1ns / 1ps

module mbps_scan #(
  parameter int MAX_SIGNATURE_LEN = 16,
  parameter int OFFSET_WIDTH      = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [7:0]                       in_byte,
  input  logic                             in_last,
  input  logic [mbps_pkg::LEN_W-1:0]       len_eff,
  input  logic [MAX_SIGNATURE_LEN*8-1:0]   win_sig,
  input  logic [MAX_SIGNATURE_LEN-1:0]     win_care,
  output logic                             res_valid,
  output mbps_pkg::result_t                res
);
  import mbps_pkg::*;

  logic [7:0]              byte_window [MAX_SIGNATURE_LEN];
  logic [7:0]              win_new     [MAX_SIGNATURE_LEN];
  logic [OFFSET_WIDTH-1:0] byte_position;
  logic                    match_seen;

  logic [MAX_SIGNATURE_LEN-1:0]    slot_ok;
  logic                            win_match;
  logic [OFFSET_WIDTH-1:0]         taken;
  logic [OFFSET_WIDTH-1:0]         len_ext;
  logic [OFFSET_WIDTH-1:0]         start_pos;
  logic [OFFSET_WIDTH+RESULT_OFFSET_W-1:0] start_ext;
  logic                            hit;

  // Window after this byte shifts in, newest byte in slot zero.
  always_comb begin
    win_new[0] = in_byte;
    for (int k = 1; k < MAX_SIGNATURE_LEN; k++) begin
      win_new[k] = byte_window[k-1];
    end
  end

  // Compare all slots in parallel against the realigned signature.
  always_comb begin
    for (int j = 0; j < MAX_SIGNATURE_LEN; j++) begin
      slot_ok[j] = !win_care[j] || (win_new[j] == win_sig[j*8 +: 8]);
    end
  end
  assign win_match = &slot_ok;

  // Bytes taken including this one, saturating at all ones.
  assign taken     = (&byte_position) ? byte_position : byte_position + OFFSET_WIDTH'(1);
  assign len_ext   = OFFSET_WIDTH'(len_eff);
  assign start_pos = taken - len_ext;
  assign start_ext = {{RESULT_OFFSET_W{1'b0}}, start_pos};
  assign hit       = !match_seen && (taken >= len_ext) && win_match;

  // A match reports its start; a region end without any match reports not found.
  always_comb begin
    res_valid  = in_valid && (hit || (in_last && !match_seen));
    res.found  = hit;
    res.offset = hit ? start_ext[RESULT_OFFSET_W-1:0] : '0;
  end

  // Scan state update; the region end returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      match_seen    <= 1'b0;
      for (int k = 0; k < MAX_SIGNATURE_LEN; k++) begin
        byte_window[k] <= 8'h00;
      end
    end else if (in_valid) begin
      if (in_last) begin
        byte_position <= '0;
        match_seen    <= 1'b0;
        for (int k = 0; k < MAX_SIGNATURE_LEN; k++) begin
          byte_window[k] <= 8'h00;
        end
      end else begin
        byte_position <= taken;
        match_seen    <= match_seen | hit;
        for (int k = 0; k < MAX_SIGNATURE_LEN; k++) begin
          byte_window[k] <= win_new[k];
        end
      end
    end
  end

  // Not-found results only come at the end of a region.
  a_notfound_at_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> in_last)
    else $error("not-found result away from region end");

  // After a found result inside a region, the next cycle carries no result.
  a_silent_after_found: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.found && !in_last) |=> !res_valid)
    else $error("result after a reported match in the same region");

  // A reported match implies at least one byte was counted.
  a_seen_has_position: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> (byte_position != '0))
    else $error("match flag set with empty position");

endmodule

### design/mbps_out_buf.sv
// Output register with a skid stage for the result stream.
// Depends on mbps_pkg for the result type.
`timescale 1ns / 1ps

module mbps_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mbps_pkg::result_t in_data,
  output logic              can_accept,
  output logic              out_valid,
  output mbps_pkg::result_t out_data,
  input  logic              out_ready
);
  import mbps_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    main_free;

  // The main slot can load when empty or when its transfer completes.
  assign main_free  = !out_valid || out_ready;
  assign can_accept = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers follow the same selection without reset.
  always_ff @(posedge clk) begin
    if (main_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

  // The skid stage is only ever filled behind a held main slot.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with empty output register");

  // No new result arrives while the skid stage is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(skid_valid && in_valid))
    else $error("result arrived with both stages full");

  // A drained main slot is refilled from the skid stage.
  a_skid_refill: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid stage not moved into output register");

endmodule

### design/masked_byte_pattern_search.sv
// Masked byte pattern search: finds the first masked signature match in a byte stream.
// Results are registered: each goes into the output register, or into the skid stage while that is held.
// Throughput: one byte per cycle while s_tready is high; the 16-slot window compare is a single combinational pass.
// A skid stage holds a second result while the first waits on m_tready; input stalls then.
// Reset (rst, synchronous): scan state and output stages clear, registers take defaults.
// Depends on mbps_pkg, mbps_cfg, mbps_scan and mbps_out_buf.
`timescale 1ns / 1ps

module masked_byte_pattern_search #(
  parameter int MAX_SIGNATURE_LEN = 16,
  parameter int OFFSET_WIDTH      = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // Input byte stream.
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [7:0]                               s_tdata,   // [7:0] data_byte
  input  logic                                     s_tlast,   // last_byte
  // Result stream.
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [mbps_pkg::RESULT_OFFSET_W-1:0]     m_tdata,   // [31:0] match_offset
  output logic                                     m_tuser,   // [0] found
  // Configuration port.
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0]          paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]          pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                     pready
);
  import mbps_pkg::*;

  logic [LEN_W-1:0]               len_eff;
  logic [MAX_SIGNATURE_LEN*8-1:0] win_sig;
  logic [MAX_SIGNATURE_LEN-1:0]   win_care;
  logic                           in_accept;
  logic                           res_valid;
  result_t                        res;
  result_t                        out_data;
  logic                           can_accept;

  assign s_tready  = can_accept;
  assign in_accept = s_tvalid & s_tready;

  // Configuration registers and signature alignment.
  mbps_cfg #(
    .MAX_SIGNATURE_LEN(MAX_SIGNATURE_LEN)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .len_eff  (len_eff),
    .win_sig  (win_sig),
    .win_care (win_care)
  );

  // Window, position and compare.
  mbps_scan #(
    .MAX_SIGNATURE_LEN(MAX_SIGNATURE_LEN),
    .OFFSET_WIDTH     (OFFSET_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_accept),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .len_eff   (len_eff),
    .win_sig   (win_sig),
    .win_care  (win_care),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register and skid stage.
  mbps_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (res_valid),
    .in_data    (res),
    .can_accept (can_accept),
    .out_valid  (m_tvalid),
    .out_data   (out_data),
    .out_ready  (m_tready)
  );

  assign m_tdata = out_data.offset;
  assign m_tuser = out_data.found;

endmodule
